@@ hdl/fdpc_pkg.sv @@
// Shared types, constants and helpers for the flow direction prefix classifier.
// Depends on nothing; every other file of the block imports it.

package fdpc_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int HALF_W   = 64;
   localparam int ADDR_W   = 2 * HALF_W;
   localparam int LEN_W    = 8;
   localparam int SENSOR_W = 16;
   localparam int OP_W     = 2;
   localparam int FT_W     = 4;
   localparam int PORT_W   = 16;
   localparam int PROTO_W  = 8;
   localparam int INDEX_W  = 6;

   localparam logic [LEN_W-1:0]    MAX_PREFIX_LEN   = 8'd128;
   localparam logic [SENSOR_W-1:0] UNMATCHED_RESET  = 16'd1;
   localparam logic [PROTO_W-1:0]  PROTO_TCP        = 8'd6;
   localparam logic [PORT_W-1:0]   PORT_HTTP        = 16'd80;
   localparam logic [PORT_W-1:0]   PORT_HTTPS       = 16'd443;
   localparam logic [PORT_W-1:0]   PORT_HTTP_ALT    = 16'd8080;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

   // Flow type codes
   localparam logic [FT_W-1:0] FT_IN      = 4'd0;
   localparam logic [FT_W-1:0] FT_OUT     = 4'd1;
   localparam logic [FT_W-1:0] FT_INWEB   = 4'd2;
   localparam logic [FT_W-1:0] FT_OUTWEB  = 4'd3;
   localparam logic [FT_W-1:0] FT_INNULL  = 4'd4;
   localparam logic [FT_W-1:0] FT_OUTNULL = 4'd5;
   localparam logic [FT_W-1:0] FT_EXT2EXT = 4'd7;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic [HALF_W-1:0]   prefix_hi;
      logic [HALF_W-1:0]   prefix_lo;
      logic [LEN_W-1:0]    len;
      logic [SENSOR_W-1:0] sensor;
      logic                null_flag;
   } entry_type;

   // Control toward the table
   typedef struct packed {
      logic             wr_en;
      logic             clr_en;
      logic [IDX_W-1:0] wr_idx;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_idx;
   } tbl_cmd_type;

   // Registered read from the table
   typedef struct packed {
      logic      valid;
      entry_type data;
   } tbl_rd_type;

   // Best match found so far for one address
   typedef struct packed {
      logic                found;
      logic [SENSOR_W-1:0] sensor;
      logic                null_flag;
   } match_best_type;

   function automatic logic is_web_port(input logic [PORT_W-1:0] port);
      return (port == PORT_HTTP) || (port == PORT_HTTPS) || (port == PORT_HTTP_ALT);
   endfunction

endpackage

@@ hdl/fdpc_ifs.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on fdpc_pkg for field widths.

interface fdpc_req_if import fdpc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [INDEX_W-1:0]  entry_index;
   logic [HALF_W-1:0]   addr_a_hi;
   logic [HALF_W-1:0]   addr_a_lo;
   logic [HALF_W-1:0]   addr_b_hi;
   logic [HALF_W-1:0]   addr_b_lo;
   logic [LEN_W-1:0]    prefix_len;
   logic [SENSOR_W-1:0] entry_sensor;
   logic                null_remainder;
   logic [PROTO_W-1:0]  protocol;
   logic [PORT_W-1:0]   src_port;
   logic [PORT_W-1:0]   dst_port;

   modport source (
      output valid, op, entry_index, addr_a_hi, addr_a_lo, addr_b_hi, addr_b_lo,
             prefix_len, entry_sensor, null_remainder, protocol, src_port, dst_port,
      input  ready
   );
   modport sink (
      input  valid, op, entry_index, addr_a_hi, addr_a_lo, addr_b_hi, addr_b_lo,
             prefix_len, entry_sensor, null_remainder, protocol, src_port, dst_port,
      output ready
   );
endinterface

interface fdpc_rsp_if import fdpc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FT_W-1:0]     flow_type;
   logic [SENSOR_W-1:0] sensor_out;

   modport source (output valid, flow_type, sensor_out, input ready);
   modport sink (input valid, flow_type, sensor_out, output ready);
endinterface

@@ hdl/fdpc_table.sv @@
// Prefix table: one synchronous memory of entries plus per-entry valid flops.
// Depends on fdpc_pkg for the entry and command structs.

module fdpc_table import fdpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tbl_cmd_type cmd,
   output tbl_rd_type  rd
);

   entry_type                mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   entry_type                rd_data_ff;
   logic                     rd_valid_ff;

   // Write entry payload; no reset on storage
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
   end

   // Set on write, drop on clear
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_idx] = 1'b1;
      end else if (cmd.clr_en) begin
         valid_in[cmd.wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[cmd.rd_idx];
      rd_valid_ff <= valid_ff[cmd.rd_idx];
   end

   assign rd.valid = rd_valid_ff;
   assign rd.data  = rd_data_ff;

endmodule

@@ hdl/fdpc_match.sv @@
// Masked prefix compare and best-so-far tracking for one address of a flow.
// Depends on fdpc_pkg for the read and best-match structs.

module fdpc_match import fdpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              live,
   input  tbl_rd_type        rd,
   input  logic [ADDR_W-1:0] key,
   output match_best_type    best
);

   logic [ADDR_W-1:0]   mask;
   logic [ADDR_W-1:0]   diff;
   logic                hit;
   logic                better;
   logic                found_ff, found_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [SENSOR_W-1:0] sensor_ff, sensor_in;
   logic                null_ff, null_in;

   // Build the prefix mask: bit j kept when j + len reaches the address width
   always_comb begin
      for (int j = 0; j < ADDR_W; j++) begin
         mask[j] = ({1'b0, rd.data.len} + 9'(j)) >= 9'(ADDR_W);
      end
   end

   assign diff   = (key ^ {rd.data.prefix_hi, rd.data.prefix_lo}) & mask;
   assign hit    = live && rd.valid && (diff == '0);
   // Strictly longer wins, so the lowest index keeps a tie
   assign better = !found_ff || (rd.data.len > best_len_ff);

   // Clear on start, take a better hit otherwise
   always_comb begin
      found_in    = found_ff;
      best_len_in = best_len_ff;
      sensor_in   = sensor_ff;
      null_in     = null_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (hit && better) begin
         found_in    = 1'b1;
         best_len_in = rd.data.len;
         sensor_in   = rd.data.sensor;
         null_in     = rd.data.null_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_len_ff <= best_len_in;
      sensor_ff   <= sensor_in;
      null_ff     <= null_in;
   end

   assign best.found     = found_ff;
   assign best.sensor    = sensor_ff;
   assign best.null_flag = null_ff;

endmodule

@@ hdl/flow_direction_prefix_classifier.sv @@
// Top level of the flow direction prefix classifier: sequencer, output register, assertions.
// Depends on fdpc_pkg, fdpc_ifs, fdpc_table and fdpc_match.
//
// Usage:
//   req_if carries table writes, table clears and classify requests; rsp_if
//   returns one flow type and sensor id per classify request. Both are
//   valid/ready channels; a transfer happens when valid and ready are high.
//   csr_wr_en/csr_wr_data set the sensor reported when no prefix matches.
// Operation:
//   A write or clear yields no response.
//   A classify scans every table slot once through the memory's single read
//   port, comparing source and destination in the same pass. The response
//   is loaded into the output register when the scan ends, and no new
//   request is taken while the scan runs.
// Reset:
//   Synchronous, active high. All slots become invalid, the unmatched sensor
//   returns to 1 and any pending response is dropped.
// Stall:
//   The response sits in an output register. Requests keep flowing while it
//   waits; a classify that finishes meanwhile holds until the register frees.

module flow_direction_prefix_classifier import fdpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   fdpc_req_if.sink            req_if,
   fdpc_rsp_if.source          rsp_if,
   input  logic                csr_wr_en,
   input  logic [SENSOR_W-1:0] csr_wr_data
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                live_ff, live_in;
   logic [ADDR_W-1:0]   src_key_ff;
   logic [ADDR_W-1:0]   dst_key_ff;
   logic                web_ff;
   logic [SENSOR_W-1:0] unmatched_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FT_W-1:0]     rsp_type_ff, rsp_type_in;
   logic [SENSOR_W-1:0] rsp_sensor_ff, rsp_sensor_in;

   logic           req_accept;
   logic           in_range;
   logic           start;
   logic           issue;
   logic           finish;
   logic [LEN_W-1:0] len_sat;
   tbl_cmd_type    cmd;
   tbl_rd_type     rd;
   match_best_type src_best;
   match_best_type dst_best;
   logic [FT_W-1:0]     res_type;
   logic [SENSOR_W-1:0] res_sensor;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign in_range     = 32'(req_if.entry_index) < TABLE_ENTRIES;
   assign start        = req_accept && (req_if.op == OP_CLASSIFY);
   assign len_sat      = (req_if.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                               : req_if.prefix_len;

   // Issue one slot read per cycle until the table is covered
   assign issue  = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(TABLE_ENTRIES));
   // Done once the last read has been compared and the output register is free
   assign finish = (state_ff == ST_SCAN) && !issue && !live_ff &&
                   (!rsp_valid_ff || rsp_if.ready);

   // Table commands
   always_comb begin
      cmd.wr_en             = req_accept && (req_if.op == OP_WRITE) && in_range;
      cmd.clr_en            = req_accept && (req_if.op == OP_CLEAR) && in_range;
      cmd.wr_idx            = IDX_W'(req_if.entry_index);
      cmd.wr_data.prefix_hi = req_if.addr_a_hi;
      cmd.wr_data.prefix_lo = req_if.addr_a_lo;
      cmd.wr_data.len       = len_sat;
      cmd.wr_data.sensor    = req_if.entry_sensor;
      cmd.wr_data.null_flag = req_if.null_remainder;
      cmd.rd_idx            = IDX_W'(cnt_ff);
   end

   fdpc_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

   fdpc_match u_match_src (
      .clock (clock),
      .reset (reset),
      .start (start),
      .live  (live_ff),
      .rd    (rd),
      .key   (src_key_ff),
      .best  (src_best)
   );

   fdpc_match u_match_dst (
      .clock (clock),
      .reset (reset),
      .start (start),
      .live  (live_ff),
      .rd    (rd),
      .key   (dst_key_ff),
      .best  (dst_best)
   );

   // Source hit beats destination hit; neither gives ext2ext
   always_comb begin
      if (src_best.found) begin
         res_sensor = src_best.sensor;
         res_type   = src_best.null_flag ? FT_OUTNULL : (web_ff ? FT_OUTWEB : FT_OUT);
      end else if (dst_best.found) begin
         res_sensor = dst_best.sensor;
         res_type   = dst_best.null_flag ? FT_INNULL : (web_ff ? FT_INWEB : FT_IN);
      end else begin
         res_sensor = unmatched_ff;
         res_type   = FT_EXT2EXT;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      live_in  = issue;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on finish, drop on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_sensor_in = rsp_sensor_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_type_in   = res_type;
         rsp_sensor_in = res_sensor;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unmatched_ff <= UNMATCHED_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unmatched_ff <= csr_wr_data;
         end
      end
   end

   // Hold flow keys and response payload
   always_ff @(posedge clock) begin
      if (start) begin
         src_key_ff <= {req_if.addr_a_hi, req_if.addr_a_lo};
         dst_key_ff <= {req_if.addr_b_hi, req_if.addr_b_lo};
         web_ff     <= (req_if.protocol == PROTO_TCP) &&
                       (is_web_port(req_if.src_port) || is_web_port(req_if.dst_port));
      end
      rsp_type_ff   <= rsp_type_in;
      rsp_sensor_ff <= rsp_sensor_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.flow_type  = rsp_type_ff;
   assign rsp_if.sensor_out = rsp_sensor_ff;

   // Scan counter never runs past the table
   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("scan counter beyond table");

   // Read data is compared only during a scan
   a_live_in_scan : assert property (@(posedge clock) disable iff (reset)
      live_ff |-> (state_ff == ST_SCAN))
      else $error("compare outside scan");

   // Table writes and clears never produce a response
   a_no_rsp_table_op : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.op != OP_CLASSIFY)) |=> !$rose(rsp_valid_ff))
      else $error("response from table operation");

   // A response only appears at the end of a scan
   a_rsp_after_scan : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SCAN))
      else $error("response without scan");

endmodule
